// ===== hw/rtl/ogrm_pkg.sv =====
package ogrm_pkg;

    localparam int MAX_DIM_DEF = 128;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int OBS_W   = 16;
    localparam int CIDX_W  = 14;
    localparam int CELL_W  = 2;
    localparam int MDIM_W  = 8;
    localparam int CPM_W   = 16;
    localparam int CFG_IW  = 8;

    // obstacle arithmetic
    localparam int POS_W   = 31;           // Q16 cell position
    localparam int MAG_W   = 30;           // |position| and ray length
    localparam int SQ_W    = 60;           // px^2 + py^2
    localparam int DIVN_W  = MAG_W + 16;   // |p| << 16
    localparam int UNIT_W  = 18;           // signed step, |u| <= 65536
    localparam int UQ_W    = 17;
    localparam int Q_W     = 34;           // walking position

    localparam logic [MDIM_W-1:0] MAP_DIM_RST = 8'd100;
    localparam logic [CPM_W-1:0]  CPM_RST     = 16'd2560;

    localparam logic [CFG_IW-1:0] CFG_MAP_DIM = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_CPM     = 8'd1;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OBST  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RSVD  = 2'd3;

    localparam logic [CELL_W-1:0] CELL_FREE = 2'd0;
    localparam logic [CELL_W-1:0] CELL_OCC  = 2'd1;
    localparam logic [CELL_W-1:0] CELL_UNK  = 2'd2;

    // Q16 tangents of the sector edges
    localparam int TAN_LO   = 19880;
    localparam int TAN_HI   = 98082;
    localparam int TAN_BACK = 158218;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_MUL,
        S_SQ,
        S_SQRT,
        S_DIVX,
        S_DIVY,
        S_WALK,
        S_OCC,
        S_DONE
    } state_t;

endpackage

// ===== hw/rtl/ogrm_ram.sv =====
module ogrm_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/ogrm_isqrt.sv =====
module ogrm_isqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ogrm_pkg::SQ_W-1:0]  value,
    output logic                       done,
    output logic [ogrm_pkg::MAG_W-1:0] root
);

    localparam int SW = ogrm_pkg::SQ_W;
    localparam int STEPS = SW / 2;

    logic [SW-1:0] v_reg, r_reg, bit_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg, done_reg;
    logic [SW-1:0] trial;

    assign trial = r_reg + bit_reg;
    assign done  = done_reg;
    assign root  = r_reg[ogrm_pkg::MAG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                v_reg    <= value;
                r_reg    <= '0;
                bit_reg  <= {2'b01, {(SW-2){1'b0}}};
            end else if (busy_reg) begin
                if (v_reg >= trial) begin
                    v_reg <= v_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/ogrm_div.sv =====
module ogrm_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ogrm_pkg::DIVN_W-1:0] dividend,
    input  logic [ogrm_pkg::MAG_W-1:0]  divisor,
    output logic                        done,
    output logic [ogrm_pkg::UQ_W-1:0]   quotient
);

    localparam int NW = ogrm_pkg::DIVN_W;
    localparam int DW = ogrm_pkg::MAG_W;

    logic [NW-1:0]  n_reg;
    logic [DW-1:0]  d_reg;
    logic [DW:0]    rem_reg;
    logic [ogrm_pkg::UQ_W-1:0] q_reg;
    logic [5:0]     cnt_reg;
    logic           busy_reg, done_reg;
    logic [DW:0]    trial;
    logic           ge;

    assign trial    = {rem_reg[DW-1:0], n_reg[NW-1]};
    assign ge       = trial >= {1'b0, d_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                n_reg    <= dividend;
                d_reg    <= divisor;
                rem_reg  <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                rem_reg <= ge ? trial - {1'b0, d_reg} : trial;
                q_reg   <= {q_reg[ogrm_pkg::UQ_W-2:0], ge};
                n_reg   <= n_reg << 1;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/occupancy_grid_ray_marker_unit.sv =====
// Occupancy grid ray marker.
// Input beats (s_*) carry a function in s_tuser: clear map, add obstacle, or
// read one cell. Every beat yields exactly one result beat on m_*, holding the
// cell code in m_tdata and a read flag in m_tuser. Registers are written
// through cfg_wen/cfg_index/cfg_wdata; the user must write them only while the
// unit is idle, which the unit itself does not enforce. Items are handled one
// at a time; the map lives in one 2-bit grid RAM. Steps per item, once the
// idle state has taken the beat; the result is registered on return to idle:
//   read    : one RAM read; unknown function: straight to the result.
//   clear   : one RAM write per cell, over all MAX_DIM^2 cells.
//   obstacle: multiply, square root (2 bits a cycle), two divisions (divider,
//             1 bit a cycle, skipped at zero range), a walk marking up to
//             2*MAX_DIM+4 cells unknown, then the first of them occupied.
// After reset the grid is swept to free, during which s_tready stays low;
// configuration writes are taken throughout.
// The result sits in an output register: the next beat is accepted while it
// waits. If the receiver stalls when a new result is ready, the unit holds
// that result internally and stops accepting beats until the register frees.
module occupancy_grid_ray_marker_unit #(
    parameter int MAX_DIM = ogrm_pkg::MAX_DIM_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // obs_x[15:0], obs_y[31:16], cell_index[45:32], zero
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // cell_state[1:0], zero
    output logic        m_tuser,   // read_valid
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CW    = (AW + 1 > ogrm_pkg::CIDX_W) ? AW + 1 : ogrm_pkg::CIDX_W;
    localparam int MW    = (DW > ogrm_pkg::MDIM_W) ? DW : ogrm_pkg::MDIM_W;
    localparam int KMAX  = 2 * MAX_DIM + 4;
    localparam int KW    = $clog2(KMAX + 1);
    localparam int PW    = DW + 20;
    localparam int QW    = ogrm_pkg::Q_W;
    localparam int CXW   = QW - 16;

    ogrm_pkg::state_t state_reg, state_next;

    logic [ogrm_pkg::MDIM_W-1:0] map_dim_reg;
    logic [ogrm_pkg::CPM_W-1:0]  cpm_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_dim_reg <= ogrm_pkg::MAP_DIM_RST;
            cpm_reg     <= ogrm_pkg::CPM_RST;
        end else if (cfg_wen) begin
            if (cfg_index == ogrm_pkg::CFG_MAP_DIM) begin
                map_dim_reg <= cfg_wdata[ogrm_pkg::MDIM_W-1:0];
            end else if (cfg_index == ogrm_pkg::CFG_CPM) begin
                cpm_reg <= cfg_wdata;
            end
        end
    end

    logic [MW-1:0] md_ext, dim_w;
    logic [DW-1:0] dim;
    logic [AW:0]   dimsq;

    assign md_ext = MW'(map_dim_reg);
    always_comb begin
        if (md_ext < MW'(2)) begin
            dim_w = MW'(2);
        end else if (md_ext > MW'(MAX_DIM)) begin
            dim_w = MW'(MAX_DIM);
        end else begin
            dim_w = md_ext;
        end
    end
    assign dim   = dim_w[DW-1:0];
    assign dimsq = (AW+1)'(dim) * (AW+1)'(dim);

    // input fields
    logic [ogrm_pkg::FUNC_W-1:0]  s_func;
    logic signed [ogrm_pkg::OBS_W-1:0] s_obs_x, s_obs_y;
    logic [ogrm_pkg::CIDX_W-1:0]  s_cell_index;
    logic [CW-1:0]                ci_ext;
    logic                         s_acc;

    assign s_func       = s_tuser;
    assign s_obs_x      = s_tdata[15:0];
    assign s_obs_y      = s_tdata[31:16];
    assign s_cell_index = s_tdata[45:32];
    assign ci_ext       = CW'(s_cell_index);
    assign s_acc        = s_tvalid && s_tready;

    // RAM
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [ogrm_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    ogrm_ram #(.WIDTH(ogrm_pkg::CELL_W), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = ci_ext[AW-1:0];

    // sweep counters
    logic [AW:0]   cnt_reg;
    logic [IW-1:0] ix_reg, iy_reg;
    logic          sweep_last;

    assign sweep_last = cnt_reg == (AW+1)'(DEPTH - 1);

    // pillar sector test for the cell under the sweep
    logic signed [PW-1:0] sx, sy, say;
    logic                 pillar, in_sq;

    assign sx  = PW'($signed({1'b0, ix_reg, 1'b0})) - PW'($signed({1'b0, dim}));
    assign sy  = PW'($signed({1'b0, iy_reg, 1'b0})) - PW'($signed({1'b0, dim}));
    assign say = sy[PW-1] ? -sy : sy;
    always_comb begin
        if (sx > 0) begin
            pillar = ((say <<< 16) > sx * PW'(ogrm_pkg::TAN_LO))
                  && ((say <<< 16) < sx * PW'(ogrm_pkg::TAN_HI));
        end else if (sx < 0) begin
            pillar = (say <<< 16) < (-sx) * PW'(ogrm_pkg::TAN_BACK);
        end else begin
            pillar = 1'b0;
        end
    end
    assign in_sq = cnt_reg < dimsq;

    // obstacle datapath
    logic signed [ogrm_pkg::OBS_W-1:0] ox_reg, oy_reg;
    logic signed [ogrm_pkg::POS_W-1:0] px_reg, py_reg;
    logic signed [ogrm_pkg::OBS_W+ogrm_pkg::CPM_W:0] mx, my;
    logic [ogrm_pkg::SQ_W-1:0]  sq_sum;
    logic [ogrm_pkg::MAG_W-1:0] d_root, ax, ay;
    logic signed [ogrm_pkg::UNIT_W-1:0] ux_reg, uy_reg;
    logic [ogrm_pkg::UQ_W-1:0] quot;
    logic                      sqrt_start, sqrt_done, div_start, div_done;
    logic [ogrm_pkg::MAG_W-1:0] div_num;

    assign mx = $signed(ox_reg) * $signed({1'b0, cpm_reg});
    assign my = $signed(oy_reg) * $signed({1'b0, cpm_reg});
    assign ax = px_reg[ogrm_pkg::POS_W-1] ? ogrm_pkg::MAG_W'(-px_reg)
                                          : ogrm_pkg::MAG_W'(px_reg);
    assign ay = py_reg[ogrm_pkg::POS_W-1] ? ogrm_pkg::MAG_W'(-py_reg)
                                          : ogrm_pkg::MAG_W'(py_reg);
    // squared range, taken by the root unit as it starts
    assign sq_sum = ogrm_pkg::SQ_W'(ax) * ogrm_pkg::SQ_W'(ax)
                  + ogrm_pkg::SQ_W'(ay) * ogrm_pkg::SQ_W'(ay);
    assign div_num = (state_reg == ogrm_pkg::S_SQRT) ? ax : ay;

    ogrm_isqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (sq_sum),
        .done    (sqrt_done),
        .root    (d_root)
    );

    // the root holds its value until the next obstacle
    ogrm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({div_num, 16'd0}),
        .divisor  (d_root),
        .done     (div_done),
        .quotient (quot)
    );

    logic signed [ogrm_pkg::UNIT_W-1:0] quot_s;
    assign quot_s = $signed({1'b0, quot});

    // walk
    logic signed [QW-1:0]  qx_reg, qy_reg, tx, ty, offs;
    logic signed [CXW-1:0] cx, cy;
    logic                  step_in;
    logic [AW-1:0]         step_idx, occ_idx_reg;
    logic                  occ_ok_reg;
    logic [KW-1:0]         k_reg;

    assign offs = QW'($signed({1'b0, dim, 15'd0})) + QW'(32768);
    assign tx   = qx_reg + offs;
    assign ty   = qy_reg + offs;
    assign cx   = tx[QW-1:16];
    assign cy   = ty[QW-1:16];
    assign step_in = !cx[CXW-1] && !cy[CXW-1]
                  && (cx < CXW'($signed({1'b0, dim})))
                  && (cy < CXW'($signed({1'b0, dim})));
    assign step_idx = AW'(cx[IW-1:0]) + AW'(cy[IW-1:0]) * AW'(dim);

    // result
    logic [ogrm_pkg::CELL_W-1:0] res_cell_reg;
    logic                        res_rv_reg, rd_ok_reg;
    logic                        m_valid_reg;
    logic [ogrm_pkg::CELL_W-1:0] m_cell_reg;
    logic                        m_rv_reg;
    logic                        out_free;

    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ogrm_pkg::S_INIT: if (sweep_last) state_next = ogrm_pkg::S_IDLE;
            ogrm_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    case (s_func)
                        ogrm_pkg::FUNC_CLEAR: state_next = ogrm_pkg::S_CLEAR;
                        ogrm_pkg::FUNC_OBST:  state_next = ogrm_pkg::S_MUL;
                        ogrm_pkg::FUNC_READ:  state_next = ogrm_pkg::S_READ;
                        default:              state_next = ogrm_pkg::S_DONE;
                    endcase
                end
            end
            ogrm_pkg::S_CLEAR: if (sweep_last) state_next = ogrm_pkg::S_DONE;
            ogrm_pkg::S_READ:  state_next = ogrm_pkg::S_DONE;
            ogrm_pkg::S_MUL:   state_next = ogrm_pkg::S_SQ;
            ogrm_pkg::S_SQ:    state_next = ogrm_pkg::S_SQRT;
            ogrm_pkg::S_SQRT: begin
                if (sqrt_done) begin
                    state_next = (d_root == '0) ? ogrm_pkg::S_WALK : ogrm_pkg::S_DIVX;
                end
            end
            ogrm_pkg::S_DIVX:  if (div_done) state_next = ogrm_pkg::S_DIVY;
            ogrm_pkg::S_DIVY:  if (div_done) state_next = ogrm_pkg::S_WALK;
            ogrm_pkg::S_WALK: begin
                if (!step_in || k_reg == KW'(KMAX)) state_next = ogrm_pkg::S_OCC;
            end
            ogrm_pkg::S_OCC:   state_next = ogrm_pkg::S_DONE;
            ogrm_pkg::S_DONE:  if (out_free) state_next = ogrm_pkg::S_IDLE;
            default:           state_next = ogrm_pkg::S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        s_tready   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg[AW-1:0];
        ram_wdata  = ogrm_pkg::CELL_FREE;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ogrm_pkg::S_INIT: ram_we = 1'b1;
            ogrm_pkg::S_IDLE: s_tready = 1'b1;
            ogrm_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = (in_sq && pillar) ? ogrm_pkg::CELL_UNK : ogrm_pkg::CELL_FREE;
            end
            ogrm_pkg::S_SQ: sqrt_start = 1'b1;
            ogrm_pkg::S_SQRT: div_start = sqrt_done && d_root != '0;
            ogrm_pkg::S_DIVX: div_start = div_done;
            ogrm_pkg::S_WALK: begin
                ram_we    = step_in && k_reg != KW'(KMAX);
                ram_waddr = step_idx;
                ram_wdata = ogrm_pkg::CELL_UNK;
            end
            ogrm_pkg::S_OCC: begin
                ram_we    = occ_ok_reg;
                ram_waddr = occ_idx_reg;
                ram_wdata = ogrm_pkg::CELL_OCC;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ogrm_pkg::S_INIT;
            cnt_reg     <= '0;
            ix_reg      <= '0;
            iy_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ogrm_pkg::S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                m_cell_reg  <= res_cell_reg;
                m_rv_reg    <= res_rv_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ogrm_pkg::S_INIT, ogrm_pkg::S_CLEAR: begin
                    cnt_reg <= sweep_last ? '0 : cnt_reg + 1'b1;
                    if ((AW+1)'(ix_reg) + 1'b1 == (AW+1)'(dim)) begin
                        ix_reg <= '0;
                        iy_reg <= iy_reg + 1'b1;
                    end else begin
                        ix_reg <= ix_reg + 1'b1;
                    end
                    if (sweep_last) begin
                        ix_reg <= '0;
                        iy_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath without reset
    always_ff @(posedge aclk) begin
        case (state_reg)
            ogrm_pkg::S_IDLE: begin
                ox_reg       <= s_obs_x;
                oy_reg       <= s_obs_y;
                rd_ok_reg    <= ci_ext < CW'(dimsq);
                res_cell_reg <= ogrm_pkg::CELL_FREE;
                res_rv_reg   <= s_func == ogrm_pkg::FUNC_READ;
            end
            ogrm_pkg::S_READ: begin
                res_cell_reg <= rd_ok_reg ? ram_rdata : ogrm_pkg::CELL_FREE;
            end
            ogrm_pkg::S_MUL: begin
                px_reg <= mx[ogrm_pkg::POS_W+1:2];
                py_reg <= my[ogrm_pkg::POS_W+1:2];
            end
            ogrm_pkg::S_SQ: begin
                qx_reg <= QW'(px_reg);
                qy_reg <= QW'(py_reg);
                k_reg  <= '0;
                ux_reg <= ogrm_pkg::UNIT_W'(65536);
                uy_reg <= '0;
            end
            ogrm_pkg::S_DIVX: begin
                if (div_done) ux_reg <= px_reg[ogrm_pkg::POS_W-1] ? -quot_s : quot_s;
            end
            ogrm_pkg::S_DIVY: begin
                if (div_done) uy_reg <= py_reg[ogrm_pkg::POS_W-1] ? -quot_s : quot_s;
            end
            ogrm_pkg::S_WALK: begin
                if (k_reg == '0) begin
                    occ_ok_reg  <= step_in;
                    occ_idx_reg <= step_idx;
                end
                qx_reg <= qx_reg + QW'(ux_reg);
                qy_reg <= qy_reg + QW'(uy_reg);
                k_reg  <= k_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_cell_reg};
    assign m_tuser  = m_rv_reg;

    // no beat is taken while the grid is being swept after reset
    a_init_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ogrm_pkg::S_INIT |-> !s_tready)
        else $error("beat accepted during reset sweep");

    // walk writes stay inside the map in use
    a_walk_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && state_reg == ogrm_pkg::S_WALK |-> (AW+1)'(ram_waddr) < dimsq)
        else $error("ray write outside map");

    // a result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ogrm_pkg::S_DONE && m_valid_reg && !m_tready
        |=> $stable(m_cell_reg) && $stable(m_rv_reg))
        else $error("pending result overwritten");

    // reads report a valid flag; other functions never do and carry the free code
    a_rv_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[1:0] == ogrm_pkg::CELL_FREE)
        else $error("cell code on a non-read result");

endmodule
